// ===== rtl/cps_pkg.sv =====
// cps_pkg: shared types, constants and helpers for the cel pixel shader
// used by cps_divider and cel_pixel_shader; no dependencies
package cps_pkg;

  // number of light bands and the width of a band number
  localparam int BANDS  = 4;
  localparam int BAND_W = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_EDGES      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LEVELS     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_SHIFT       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_SAT_GAIN = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEC_THRESHOLD  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEC_GAIN       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIM_GAIN        = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIM_EXPONENT    = 4'd7;

  // divider widths: dividend, divisor, quotient (one quotient bit per stage)
  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = 19;
  localparam int DIV_Q_W   = 17;

  // log2(1+i/16) and 2^(-i/16), Q.16
  localparam logic [16:0] LOG_TAB [17] = '{
    17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
    17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
    17'd56229, 17'd59434, 17'd62534, 17'd65536
  };
  localparam logic [16:0] EXP_TAB [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  // values that ride alongside the hue and saturation division
  typedef struct packed {
    logic [15:0]      lit;
    logic [16:0]      fac;
    logic [15:0]      rot;
    logic [15:0]      v;
    logic             dz;
    logic [47:0]      spec;
    logic [32:0]      rim;
    logic [16:0]      ao;
    logic [2:0][15:0] amb;
  } side_t;

  typedef struct packed {
    logic [18:0] tot;
    logic [15:0] d;
    logic [15:0] mx;
    side_t       sd;
  } div_in_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [16:0] sat;
    side_t       sd;
  } div_out_t;

  // clamp a signed Q2.14 value to 0..1 and return it as Q.16 (0..65536)
  function automatic logic [16:0] unit_of(input logic [15:0] x);
    logic [16:0] r;
    if (x[15]) begin
      r = '0;
    end else if (x > 16'd16384) begin
      r = 17'd65536;
    end else begin
      r = {x[14:0], 2'b00};
    end
    return r;
  endfunction

endpackage

// ===== rtl/cps_divider.sv =====
// cps_divider: pipelined restoring divider for hue and saturation, one
// quotient bit per stage, carrying the shading side values along
// depends on cps_pkg
module cps_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cps_pkg::div_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cps_pkg::div_out_t  out_data
);

  localparam int QW = cps_pkg::DIV_Q_W;
  localparam int NW = cps_pkg::DIV_NUM_W;
  localparam int DW = cps_pkg::DIV_DEN_W;

  logic [QW-1:0]  v;
  logic [QW-1:0]  en;
  logic [NW-1:0]  rh [QW];
  logic [NW-1:0]  rs [QW];
  logic [DW-1:0]  dh [QW];
  logic [DW-1:0]  ds [QW];
  logic [QW-1:0]  qh [QW];
  logic [QW-1:0]  qs [QW];
  cps_pkg::side_t side_q [QW];

  logic [NW-1:0]  rh_next [QW];
  logic [NW-1:0]  rs_next [QW];
  logic [DW-1:0]  dh_next [QW];
  logic [DW-1:0]  ds_next [QW];
  logic [QW-1:0]  qh_next [QW];
  logic [QW-1:0]  qs_next [QW];
  cps_pkg::side_t side_next [QW];

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[QW-1] = !v[QW-1] || out_ready;
    for (int j = QW - 2; j >= 0; j--) begin
      en[j] = !v[j] || en[j+1];
    end
  end

  assign in_ready = en[0];

  // one restoring step per stage for both quotients
  always_comb begin
    logic [NW-1:0] ph, ps, bh, bs;
    logic [DW-1:0] pdh, pds;
    logic [QW-1:0] pqh, pqs;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        ph  = {1'b0, in_data.tot, 16'b0};
        ps  = {4'b0, in_data.d, 16'b0};
        pdh = ({3'b0, in_data.d} << 2) + ({3'b0, in_data.d} << 1);
        pds = {3'b0, in_data.mx};
        pqh = '0;
        pqs = '0;
        side_next[j] = in_data.sd;
      end else begin
        ph  = rh[j-1];
        ps  = rs[j-1];
        pdh = dh[j-1];
        pds = ds[j-1];
        pqh = qh[j-1];
        pqs = qs[j-1];
        side_next[j] = side_q[j-1];
      end
      bh = NW'(pdh) << (QW - 1 - j);
      bs = NW'(pds) << (QW - 1 - j);
      dh_next[j] = pdh;
      ds_next[j] = pds;
      if (ph >= bh) begin
        rh_next[j] = ph - bh;
        qh_next[j] = pqh | (QW'(1) << (QW - 1 - j));
      end else begin
        rh_next[j] = ph;
        qh_next[j] = pqh;
      end
      if (ps >= bs) begin
        rs_next[j] = ps - bs;
        qs_next[j] = pqs | (QW'(1) << (QW - 1 - j));
      end else begin
        rs_next[j] = ps;
        qs_next[j] = pqs;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int j = 0; j < QW; j++) begin
        if (en[j]) begin
          v[j] <= (j == 0) ? in_valid : v[j-1];
        end
      end
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    for (int j = 0; j < QW; j++) begin
      if (en[j]) begin
        rh[j]     <= rh_next[j];
        rs[j]     <= rs_next[j];
        dh[j]     <= dh_next[j];
        ds[j]     <= ds_next[j];
        qh[j]     <= qh_next[j];
        qs[j]     <= qs_next[j];
        side_q[j] <= side_next[j];
      end
    end
  end

  assign out_valid    = v[QW-1];
  assign out_data.hue = qh[QW-1][15:0];
  assign out_data.sat = qs[QW-1];
  assign out_data.sd  = side_q[QW-1];

  // a finished saturation division leaves a remainder below the divisor
  a_sat_rem : assert property (@(posedge clk) disable iff (rst)
    (v[QW-1] && ds[QW-1] != '0) |-> (rs[QW-1] < NW'(ds[QW-1])))
    else $error("saturation remainder not below divisor");

  // a finished hue division leaves a remainder below the divisor
  a_hue_rem : assert property (@(posedge clk) disable iff (rst)
    (v[QW-1] && dh[QW-1] != '0) |-> (rh[QW-1] < NW'(dh[QW-1])))
    else $error("hue remainder not below divisor");

  // an output beat held by the consumer stays valid
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    (v[QW-1] && !out_ready) |=> v[QW-1])
    else $error("divider output beat lost under stall");

endmodule

// ===== rtl/cel_pixel_shader.sv =====
// cel_pixel_shader: top level of the fixed point cel shading pipeline
// depends on cps_pkg and cps_divider
//
// Takes one pixel's shading terms per beat and returns one shaded RGB
// beat per pixel, one pixel per clock sustained when the output is not
// stalled. The pipeline has six front stages (banding, lit fraction, rim
// power through log2/exp2 tables), seventeen divider stages that produce
// hue and saturation one quotient bit per stage, and seven back stages
// (hue/saturation remap, HSV to RGB, lighting sums, saturation to Q4.12).
// Stalls on the output hold every stage that is full; empty stages keep
// accepting. Register writes are taken every cycle (cfg_ready is always
// high) and must only happen while no pixel is in flight.
module cel_pixel_shader (
  input  logic          clk,
  input  logic          rst,
  // config write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  // input pixel stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // light_dot, shadow_factor, albedo_red, albedo_green, albedo_blue,
  // gloss_amount, half_dot, view_dot, occlusion, ambient_red,
  // ambient_green, ambient_blue (16 bits each, from bit 0 up)
  input  logic [191:0]  s_axis_tdata,
  // output pixel stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // shaded_red, shaded_green, shaded_blue (16 bits each, from bit 0 up)
  output logic [47:0]   m_axis_tdata
);

  localparam int FN = 6;
  localparam int BN = 7;
  localparam int BAND_W_T = cps_pkg::BAND_W;

  typedef struct packed {
    logic [15:0]      lvl;
    logic [16:0]      shadow;
    logic [18:0]      tot;
    logic [15:0]      d;
    logic [15:0]      mx;
    logic             spec_on;
    logic [14:0]      gloss;
    logic [16:0]      base;
    logic [16:0]      ao;
    logic [2:0][15:0] amb;
    logic [15:0]      lit;
    logic [16:0]      k;
    logic [30:0]      spec_gs;
    logic             pw_one;
    logic             pw_zero;
    logic [4:0]       sh;
    logic [15:0]      frac;
    logic [16:0]      lf;
    logic [47:0]      spec;
    logic [16:0]      fac;
    logic [15:0]      rot;
    logic [8:0]       ip;
    logic [15:0]      fp;
    logic [16:0]      pw;
    logic [32:0]      rim;
  } front_t;

  typedef struct packed {
    cps_pkg::side_t   sd;
    logic [15:0]      hue;
    logic [16:0]      s;
    logic [2:0]       sec;
    logic [16:0]      parg;
    logic [16:0]      qarg;
    logic [16:0]      targ;
    logic [2:0][15:0] tint;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0][48:0] b2;
    logic [50:0]      c;
    logic [2:0][49:0] t1;
    logic [2:0][15:0] rgb;
  } back_t;

  // configuration registers
  logic [47:0] band_edges;
  logic [63:0] band_levels;
  logic [15:0] hue_shift;
  logic [15:0] shadow_sat_gain;
  logic [15:0] spec_threshold;
  logic [15:0] spec_gain;
  logic [15:0] rim_gain;
  logic [15:0] rim_exponent;

  logic [FN-1:0] fv, fen;
  logic [BN-1:0] bv, ben;
  front_t fs [FN];
  back_t  bs [BN];
  front_t f0_next, f1_next, f2_next, f3_next, f4_next, f5_next;
  back_t  b0_next, b1_next, b2_next, b3_next, b4_next, b5_next, b6_next;

  logic               div_in_ready;
  logic               div_out_valid;
  cps_pkg::div_in_t   div_in;
  cps_pkg::div_out_t  div_out;

  // register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_edges      <= '0;
      band_levels     <= '0;
      hue_shift       <= '0;
      shadow_sat_gain <= 16'd16384;
      spec_threshold  <= 16'd16384;
      spec_gain       <= '0;
      rim_gain        <= '0;
      rim_exponent    <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cps_pkg::REG_BAND_EDGES:      band_edges      <= cfg_data[47:0];
        cps_pkg::REG_BAND_LEVELS:     band_levels     <= cfg_data;
        cps_pkg::REG_HUE_SHIFT:       hue_shift       <= cfg_data[15:0];
        cps_pkg::REG_SHADOW_SAT_GAIN: shadow_sat_gain <= cfg_data[15:0];
        cps_pkg::REG_SPEC_THRESHOLD:  spec_threshold  <= cfg_data[15:0];
        cps_pkg::REG_SPEC_GAIN:       spec_gain       <= cfg_data[15:0];
        cps_pkg::REG_RIM_GAIN:        rim_gain        <= cfg_data[15:0];
        cps_pkg::REG_RIM_EXPONENT:    rim_exponent    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage enables
  always_comb begin
    fen[FN-1] = !fv[FN-1] || div_in_ready;
    for (int i = FN - 2; i >= 0; i--) begin
      fen[i] = !fv[i] || fen[i+1];
    end
    ben[BN-1] = !bv[BN-1] || m_axis_tready;
    for (int i = BN - 2; i >= 0; i--) begin
      ben[i] = !bv[i] || ben[i+1];
    end
  end

  assign s_axis_tready = fen[0];

  // front 0: clamps, band search, max/min and hue numerator
  always_comb begin
    logic [16:0] ndl;
    logic [BAND_W_T-1:0] band;
    logic [15:0] r, g, b, mx, mn, d;
    logic signed [20:0] tot, d6;
    f0_next = fs[0];
    ndl  = cps_pkg::unit_of(s_axis_tdata[15:0]);
    band = '0;
    for (int i = 0; i < cps_pkg::BANDS - 1 && i < 3; i++) begin
      if (ndl > {1'b0, band_edges[16*i +: 16]}) begin
        band = BAND_W_T'(i + 1);
      end
    end
    f0_next.lvl    = band_levels[16*band +: 16];
    f0_next.shadow = cps_pkg::unit_of(s_axis_tdata[31:16]);
    r = s_axis_tdata[47:32];
    g = s_axis_tdata[63:48];
    b = s_axis_tdata[79:64];
    mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    d  = mx - mn;
    d6 = $signed({3'b0, d, 2'b0}) + $signed({4'b0, d, 1'b0});
    if (mx == r) begin
      tot = $signed({5'b0, g}) - $signed({5'b0, b});
    end else if (mx == g) begin
      tot = $signed({4'b0, d, 1'b0}) + $signed({5'b0, b}) - $signed({5'b0, r});
    end else begin
      tot = $signed({3'b0, d, 2'b0}) + $signed({5'b0, r}) - $signed({5'b0, g});
    end
    if (tot < 0) begin
      tot = tot + d6;
    end
    f0_next.tot     = tot[18:0];
    f0_next.d       = d;
    f0_next.mx      = mx;
    f0_next.spec_on = !s_axis_tdata[95] && (s_axis_tdata[95:80] != '0) &&
                      ($signed(s_axis_tdata[111:96]) >= $signed(spec_threshold));
    f0_next.gloss   = s_axis_tdata[94:80];
    f0_next.base    = 17'd65536 - cps_pkg::unit_of(s_axis_tdata[127:112]);
    f0_next.ao      = cps_pkg::unit_of(s_axis_tdata[143:128]);
    f0_next.amb[0]  = s_axis_tdata[159:144];
    f0_next.amb[1]  = s_axis_tdata[175:160];
    f0_next.amb[2]  = s_axis_tdata[191:176];
  end

  // front 1: lit fraction, gloss times gain, log2 normalization
  always_comb begin
    logic [32:0] lp;
    logic [31:0] sh32;
    logic [3:0]  n;
    f1_next = fs[0];
    lp = fs[0].lvl * fs[0].shadow;
    f1_next.lit = lp[31:16];
    f1_next.k   = 17'd65536 - {1'b0, lp[31:16]};
    f1_next.spec_gs = fs[0].spec_on ? (fs[0].gloss * spec_gain) : '0;
    f1_next.pw_one  = (rim_exponent == '0) || fs[0].base[16];
    f1_next.pw_zero = (fs[0].base == '0);
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (fs[0].base[i]) begin
        n = 4'(i);
      end
    end
    f1_next.sh = 5'd16 - {1'b0, n};
    sh32 = {16'b0, fs[0].base[15:0]} << f1_next.sh;
    f1_next.frac = sh32[15:0];
  end

  // front 2: log2 interpolation, highlight, saturation factor, hue rotation
  always_comb begin
    logic [4:0]  li;
    logic [28:0] lm;
    logic [32:0] p1;
    logic [33:0] fsum;
    logic signed [33:0] rp;
    f2_next = fs[1];
    li = {1'b0, fs[1].frac[15:12]};
    lm = (cps_pkg::LOG_TAB[li + 5'd1] - cps_pkg::LOG_TAB[li]) * fs[1].frac[11:0];
    f2_next.lf   = cps_pkg::LOG_TAB[li] + lm[28:12];
    f2_next.spec = fs[1].spec_gs * fs[1].shadow;
    p1   = shadow_sat_gain * fs[1].k;
    fsum = {1'b0, p1} + {3'b0, (17'd65536 - fs[1].k), 14'b0};
    f2_next.fac = fsum[32:16];
    rp = $signed(hue_shift) * $signed({1'b0, fs[1].k});
    f2_next.rot = rp[30:15];
  end

  // front 3: exponent product
  always_comb begin
    logic [20:0] neg;
    logic [36:0] yp;
    f3_next = fs[2];
    neg = {fs[2].sh, 16'b0} - {4'b0, fs[2].lf};
    yp  = neg * rim_exponent;
    f3_next.ip = yp[36:28];
    f3_next.fp = yp[27:12];
  end

  // front 4: exp2 interpolation and shift
  always_comb begin
    logic [4:0]  ei;
    logic [28:0] em;
    logic [16:0] r;
    f4_next = fs[3];
    ei = {1'b0, fs[3].fp[15:12]};
    em = (cps_pkg::EXP_TAB[ei] - cps_pkg::EXP_TAB[ei + 5'd1]) * fs[3].fp[11:0];
    r  = cps_pkg::EXP_TAB[ei] - em[28:12];
    priority if (fs[3].pw_one) begin
      f4_next.pw = 17'd65536;
    end else if (fs[3].pw_zero || fs[3].ip > 9'd16) begin
      f4_next.pw = '0;
    end else begin
      f4_next.pw = r >> fs[3].ip[4:0];
    end
  end

  // front 5: rim term
  always_comb begin
    f5_next = fs[4];
    f5_next.rim = rim_gain * fs[4].pw;
  end

  // front valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      for (int i = 0; i < FN; i++) begin
        if (fen[i]) begin
          fv[i] <= (i == 0) ? s_axis_tvalid : fv[i-1];
        end
      end
    end
  end

  // front stage data
  always_ff @(posedge clk) begin
    if (fen[0]) fs[0] <= f0_next;
    if (fen[1]) fs[1] <= f1_next;
    if (fen[2]) fs[2] <= f2_next;
    if (fen[3]) fs[3] <= f3_next;
    if (fen[4]) fs[4] <= f4_next;
    if (fen[5]) fs[5] <= f5_next;
  end

  // hand over to the divider
  always_comb begin
    div_in.tot     = fs[FN-1].tot;
    div_in.d       = fs[FN-1].d;
    div_in.mx      = fs[FN-1].mx;
    div_in.sd.lit  = fs[FN-1].lit;
    div_in.sd.fac  = fs[FN-1].fac;
    div_in.sd.rot  = fs[FN-1].rot;
    div_in.sd.v    = fs[FN-1].mx;
    div_in.sd.dz   = (fs[FN-1].d == '0);
    div_in.sd.spec = fs[FN-1].spec;
    div_in.sd.rim  = fs[FN-1].rim;
    div_in.sd.ao   = fs[FN-1].ao;
    div_in.sd.amb  = fs[FN-1].amb;
  end

  cps_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fv[FN-1]),
    .in_ready  (div_in_ready),
    .in_data   (div_in),
    .out_valid (div_out_valid),
    .out_ready (ben[0]),
    .out_data  (div_out)
  );

  // back 0: rotate hue, scale and clamp saturation
  always_comb begin
    logic [16:0] s0;
    logic [33:0] sp;
    b0_next    = bs[0];
    b0_next.sd = div_out.sd;
    s0 = div_out.sd.dz ? '0 : div_out.sat;
    b0_next.hue = (div_out.sd.dz ? 16'd0 : div_out.hue) + div_out.sd.rot;
    sp = s0 * div_out.sd.fac;
    b0_next.s = (sp[33:14] > 20'd65536) ? 17'd65536 : sp[30:14];
  end

  // back 1: sector and HSV to RGB multipliers
  always_comb begin
    logic [18:0] h6;
    logic [15:0] f;
    logic [32:0] sfp;
    logic [33:0] stp;
    b1_next = bs[0];
    h6 = ({3'b0, bs[0].hue} << 2) + ({3'b0, bs[0].hue} << 1);
    f  = h6[15:0];
    b1_next.sec = h6[18:16];
    sfp = bs[0].s * f;
    stp = bs[0].s * (17'd65536 - {1'b0, f});
    b1_next.parg = 17'd65536 - bs[0].s;
    b1_next.qarg = 17'd65536 - sfp[32:16];
    b1_next.targ = 17'd65536 - stp[32:16];
  end

  // back 2: p, q, t and the tint
  always_comb begin
    logic [32:0] pp, qp, tp;
    logic [15:0] v, p, q, t;
    b2_next = bs[1];
    v  = bs[1].sd.v;
    pp = v * bs[1].parg;
    qp = v * bs[1].qarg;
    tp = v * bs[1].targ;
    p = pp[31:16];
    q = qp[31:16];
    t = tp[31:16];
    unique case (bs[1].sec)
      3'd0: b2_next.tint = {p, t, v};
      3'd1: b2_next.tint = {p, v, q};
      3'd2: b2_next.tint = {t, v, p};
      3'd3: b2_next.tint = {v, q, p};
      3'd4: b2_next.tint = {v, p, t};
      default: b2_next.tint = {q, p, v};
    endcase
  end

  // back 3: tint products, highlight plus rim
  always_comb begin
    b3_next = bs[2];
    for (int c = 0; c < 3; c++) begin
      b3_next.a[c] = bs[2].tint[c] * bs[2].sd.lit;
      b3_next.b[c] = bs[2].tint[c] * bs[2].sd.amb[c];
    end
    b3_next.c = {1'b0, bs[2].sd.spec, 2'b0} + {2'b0, bs[2].sd.rim, 16'b0};
  end

  // back 4: ambient times occlusion
  always_comb begin
    b4_next = bs[3];
    for (int c = 0; c < 3; c++) begin
      b4_next.b2[c] = bs[3].b[c] * bs[3].sd.ao;
    end
  end

  // back 5: direct plus ambient
  always_comb begin
    b5_next = bs[4];
    for (int c = 0; c < 3; c++) begin
      b5_next.t1[c] = {4'b0, bs[4].a[c], 14'b0} + {1'b0, bs[4].b2[c]};
    end
  end

  // back 6: add highlight and rim, scale to Q4.12 and saturate
  always_comb begin
    logic [51:0] sum;
    b6_next = bs[5];
    for (int c = 0; c < 3; c++) begin
      sum = {2'b0, bs[5].t1[c]} + {1'b0, bs[5].c};
      b6_next.rgb[c] = (sum[51:50] != '0) ? 16'hFFFF : sum[49:34];
    end
  end

  // back valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else begin
      for (int i = 0; i < BN; i++) begin
        if (ben[i]) begin
          bv[i] <= (i == 0) ? div_out_valid : bv[i-1];
        end
      end
    end
  end

  // back stage data
  always_ff @(posedge clk) begin
    if (ben[0]) bs[0] <= b0_next;
    if (ben[1]) bs[1] <= b1_next;
    if (ben[2]) bs[2] <= b2_next;
    if (ben[3]) bs[3] <= b3_next;
    if (ben[4]) bs[4] <= b4_next;
    if (ben[5]) bs[5] <= b5_next;
    if (ben[6]) bs[6] <= b6_next;
  end

  assign m_axis_tvalid = bv[BN-1];
  assign m_axis_tdata  = {bs[BN-1].rgb[2], bs[BN-1].rgb[1], bs[BN-1].rgb[0]};

  // scaled saturation never exceeds one
  a_sat_clamp : assert property (@(posedge clk) disable iff (rst)
    bv[0] |-> (bs[0].s <= 17'd65536))
    else $error("saturation above one");

  // hue below one turn keeps the sector in range
  a_sector : assert property (@(posedge clk) disable iff (rst)
    bv[1] |-> (bs[1].sec <= 3'd5))
    else $error("hue sector out of range");

  // grey albedo gives a grey tint
  a_grey : assert property (@(posedge clk) disable iff (rst)
    (bv[2] && bs[2].sd.dz) |->
      (bs[2].tint[0] == bs[2].sd.v && bs[2].tint[1] == bs[2].sd.v &&
       bs[2].tint[2] == bs[2].sd.v))
    else $error("grey albedo produced a colored tint");

  // a front beat blocked by the divider is kept
  a_front_hold : assert property (@(posedge clk) disable iff (rst)
    (fv[FN-1] && !div_in_ready) |=> fv[FN-1])
    else $error("front beat lost under stall");

endmodule

// ===== sim/cel_pixel_shader_tb.sv =====
// cel_pixel_shader_tb: self-checking testbench for the cel pixel shader
// depends on cps_pkg and the cel_pixel_shader rtl; predicts each shaded pixel in place
module cel_pixel_shader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int LATENCY = 30;
  // an index with no register behind it
  localparam logic [3:0] REG_UNMAPPED = 4'd9;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [3:0]   cfg_index;
  logic [63:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;

  typedef struct {
    logic [15:0] light, shadow;
    logic [15:0] alb [3];
    logic [15:0] gloss, half, view, occ;
    logic [15:0] amb [3];
  } pixel_t;

  // local copy of the shader registers
  logic [47:0] edges_q;
  logic [63:0] levels_q;
  logic [15:0] hue_shift_q, sat_gain_q, spec_thr_q, spec_gain_q, rim_gain_q, rim_exp_q;

  logic [47:0] shaded_q [$];
  int errors = 0;
  int idle_cycles = 0;
  bit in_gaps, out_gaps;

  localparam logic [16:0] LOGT [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109,
    34312, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
  localparam logic [16:0] EXPT [17] = '{65536, 62757, 60097, 57549, 55109, 52773,
    50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  cel_pixel_shader dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // clamp a signed Q2.14 term to a Q.16 unit value
  function automatic longint unsigned clamp_unit(logic [15:0] x);
    int c;
    c = int'($signed(x));
    if (c < 0) c = 0;
    if (c > 16384) c = 16384;
    return longint'(c) * 4;
  endfunction

  // base^exponent through the log2 / exp2 tables
  function automatic longint unsigned falloff_pow(longint unsigned base, longint unsigned e);
    int n;
    longint unsigned mant, frac, lf, neg, y, ip, fp, r;
    int idx, rem;
    n = 15;
    if (e == 0 || base >= 65536) return 65536;
    if (base == 0) return 0;
    while (n > 0 && !base[n]) n--;
    mant = base << (16 - n);
    frac = mant - 65536;
    idx = int'((frac >> 12) & 15);
    rem = int'(frac & 4095);
    lf = LOGT[idx] + (((LOGT[idx+1] - LOGT[idx]) * longint'(rem)) >> 12);
    neg = longint'(16 - n) * 65536 - lf;
    y = (neg * e) >> 12;
    ip = y >> 16;
    fp = y & 16'hFFFF;
    if (ip > 16) return 0;
    idx = int'((fp >> 12) & 15);
    rem = int'(fp & 4095);
    r = EXPT[idx] - (((EXPT[idx] - EXPT[idx+1]) * longint'(rem)) >> 12);
    return r >> ip;
  endfunction

  // full shading of one pixel under the current registers
  function automatic logic [47:0] shade_pixel(pixel_t p);
    longint unsigned ndl, shadow, lit, k, spec, rim, ao, sum;
    longint unsigned r, g, b, mx, mn, d, hue, s, v, fac, h6, f, pp, qq, tt, rot;
    longint unsigned tint [3];
    longint tot, prod;
    int band, sec;
    logic [47:0] res;
    ndl = clamp_unit(p.light);
    shadow = clamp_unit(p.shadow);
    band = 0;
    for (int i = 0; i < 3; i++)
      if (ndl > edges_q[16*i +: 16]) band = i + 1;
    lit = (longint'(levels_q[16*band +: 16]) * shadow) >> 16;
    k = 65536 - lit;
    // rgb to hsv
    r = p.alb[0]; g = p.alb[1]; b = p.alb[2];
    mx = r > g ? (r > b ? r : b) : (g > b ? g : b);
    mn = r < g ? (r < b ? r : b) : (g < b ? g : b);
    d = mx - mn; hue = 0; s = 0; v = mx;
    if (d > 0) begin
      if (mx == r) tot = longint'(g) - longint'(b);
      else if (mx == g) tot = 2 * longint'(d) + longint'(b) - longint'(r);
      else tot = 4 * longint'(d) + longint'(r) - longint'(g);
      if (tot < 0) tot += 6 * longint'(d);
      hue = ((longint'(tot) << 16) / (6 * d)) & 16'hFFFF;
    end
    if (mx > 0) s = (d << 16) / mx;
    prod = longint'($signed(hue_shift_q)) * longint'(k);
    rot = (prod >>> 15) & 16'hFFFF;
    hue = (hue + rot) & 16'hFFFF;
    fac = (longint'(sat_gain_q) * k + 16384 * (65536 - k)) >> 16;
    s = (s * fac) >> 14;
    if (s > 65536) s = 65536;
    // hsv back to rgb
    h6 = hue * 6;
    sec = int'(h6 >> 16);
    f = h6 & 16'hFFFF;
    pp = (v * (65536 - s)) >> 16;
    qq = (v * (65536 - ((s * f) >> 16))) >> 16;
    tt = (v * (65536 - ((s * (65536 - f)) >> 16))) >> 16;
    case (sec)
      0: begin tint[0] = v; tint[1] = tt; tint[2] = pp; end
      1: begin tint[0] = qq; tint[1] = v; tint[2] = pp; end
      2: begin tint[0] = pp; tint[1] = v; tint[2] = tt; end
      3: begin tint[0] = pp; tint[1] = qq; tint[2] = v; end
      4: begin tint[0] = tt; tint[1] = pp; tint[2] = v; end
      default: begin tint[0] = v; tint[1] = pp; tint[2] = qq; end
    endcase
    // lighting terms
    spec = 0;
    if ($signed(p.gloss) > 0 && $signed(p.half) >= $signed(spec_thr_q))
      spec = (longint'(p.gloss) * spec_gain_q * shadow) << 2;
    rim = (longint'(rim_gain_q) * falloff_pow(65536 - clamp_unit(p.view), rim_exp_q)) << 16;
    ao = clamp_unit(p.occ);
    for (int c = 0; c < 3; c++) begin
      sum = ((tint[c] * lit) << 14) + tint[c] * p.amb[c] * ao + spec + rim;
      sum >>= 34;
      res[16*c +: 16] = sum > 65535 ? 16'hFFFF : sum[15:0];
    end
    return res;
  endfunction

  // idle burst on the sending side
  task automatic sender_gap();
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // send one pixel beat and queue its prediction
  task automatic send_pixel(pixel_t p);
    sender_gap();
    s_axis_tdata <= {p.amb[2], p.amb[1], p.amb[0], p.occ, p.view, p.half, p.gloss,
                     p.alb[2], p.alb[1], p.alb[0], p.shadow, p.light};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    shaded_q.push_back(shade_pixel(p));
    @(negedge clk);
  endtask

  // register write while the pipeline is empty
  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cps_pkg::REG_BAND_EDGES:      edges_q = val[47:0];
      cps_pkg::REG_BAND_LEVELS:     levels_q = val;
      cps_pkg::REG_HUE_SHIFT:       hue_shift_q = val[15:0];
      cps_pkg::REG_SHADOW_SAT_GAIN: sat_gain_q = val[15:0];
      cps_pkg::REG_SPEC_THRESHOLD:  spec_thr_q = val[15:0];
      cps_pkg::REG_SPEC_GAIN:       spec_gain_q = val[15:0];
      cps_pkg::REG_RIM_GAIN:        rim_gain_q = val[15:0];
      cps_pkg::REG_RIM_EXPONENT:    rim_exp_q = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and wait until every pixel has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (shaded_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // random 16-bit value biased toward the clamp edges
  function automatic logic [15:0] rand_dot();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 16384));
      1: return 16'd16384;
      2: return 16'd0;
      3: return 16'($urandom_range(0, 20000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.light = rand_dot(); p.shadow = rand_dot();
    p.gloss = rand_dot(); p.half = rand_dot();
    p.view = rand_dot(); p.occ = rand_dot();
    for (int c = 0; c < 3; c++) begin
      p.alb[c] = 16'($urandom);
      p.amb[c] = 16'($urandom);
    end
    // grey or tied-maximum albedo now and then
    if ($urandom_range(0, 7) == 0) begin p.alb[1] = p.alb[0]; p.alb[2] = p.alb[0]; end
    else if ($urandom_range(0, 7) == 0) p.alb[1] = p.alb[0];
    else if ($urandom_range(0, 7) == 0) p.alb[2] = p.alb[1];
    return p;
  endfunction

  function automatic pixel_t flat_pixel(logic [15:0] dot, logic [15:0] col);
    pixel_t p;
    p.light = dot; p.shadow = dot; p.gloss = dot; p.half = dot;
    p.view = dot; p.occ = dot;
    for (int c = 0; c < 3; c++) begin p.alb[c] = col; p.amb[c] = col; end
    return p;
  endfunction

  // random settings of all registers, extremes included
  task automatic randomize_regs(bit extreme);
    logic [15:0] e0, e1, e2;
    e0 = 16'($urandom); e1 = 16'($urandom); e2 = 16'($urandom);
    if ($urandom_range(0, 1)) begin
      e0 = 16'($urandom_range(0, 20000)); e1 = e0 + 16'($urandom_range(0, 20000));
      e2 = e1 + 16'($urandom_range(0, 20000));
      if (e2 < e1) e2 = 16'hFFFF;
    end
    write_reg(cps_pkg::REG_BAND_EDGES, {16'($urandom), e2, e1, e0});
    write_reg(cps_pkg::REG_BAND_LEVELS,
              extreme ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
    write_reg(cps_pkg::REG_HUE_SHIFT, extreme ? 64'h8000 : 64'($urandom));
    write_reg(cps_pkg::REG_SHADOW_SAT_GAIN, extreme ? 64'hFFFF : 64'($urandom));
    write_reg(cps_pkg::REG_SPEC_THRESHOLD, extreme ? 64'h8000 : 64'($urandom));
    write_reg(cps_pkg::REG_SPEC_GAIN, extreme ? 64'hFFFF : 64'($urandom));
    write_reg(cps_pkg::REG_RIM_GAIN, extreme ? 64'hFFFF : 64'($urandom));
    write_reg(cps_pkg::REG_RIM_EXPONENT, extreme ? 64'hFFFF
              : 64'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16384)));
  endtask

  // extremes of every field, grey and tied albedo, gloss and rim corners
  task automatic test_directed();
    pixel_t p;
    send_pixel(flat_pixel(16'h0000, 16'h0000));
    send_pixel(flat_pixel(16'h4000, 16'hFFFF));
    send_pixel(flat_pixel(16'h7FFF, 16'hFFFF));
    send_pixel(flat_pixel(16'h8000, 16'h8000));
    send_pixel(flat_pixel(16'hFFFF, 16'h1234));
    drain();
    write_reg(cps_pkg::REG_BAND_EDGES, 64'h0000_C000_8000_4000);
    write_reg(cps_pkg::REG_BAND_LEVELS, 64'hFFFF_C000_8000_4000);
    write_reg(cps_pkg::REG_SPEC_GAIN, 64'h4000);
    write_reg(cps_pkg::REG_RIM_GAIN, 64'h4000);
    write_reg(cps_pkg::REG_HUE_SHIFT, 64'h2000);
    write_reg(REG_UNMAPPED, 64'hFFFF);   // unknown index, ignored
    for (int i = 0; i < 5; i++) begin
      p = flat_pixel(16'(i * 4096), 16'h8000);
      p.alb[0] = 16'hFFFF; p.alb[1] = 16'(i * 9000); p.alb[2] = 16'h0100;
      send_pixel(p);
    end
    // equal maxima and grey
    p = flat_pixel(16'h3000, 16'h9000); p.alb[2] = 16'h1000; send_pixel(p);
    p = flat_pixel(16'h3000, 16'h9000); p.alb[0] = 16'h1000; send_pixel(p);
    p = flat_pixel(16'h3000, 16'h5555); send_pixel(p);
    // gloss not positive, highlight at threshold
    p = flat_pixel(16'h4000, 16'h7000); p.gloss = 16'h0000; send_pixel(p);
    p = flat_pixel(16'h4000, 16'h7000); p.gloss = 16'hC000; send_pixel(p);
    p = flat_pixel(16'h4000, 16'h7000); p.half = 16'h4000; send_pixel(p);
    drain();
    // zero exponent with zero base, deep exp2
    write_reg(cps_pkg::REG_RIM_EXPONENT, 64'h0);
    p = flat_pixel(16'h4000, 16'h7000); send_pixel(p);
    drain();
    write_reg(cps_pkg::REG_RIM_EXPONENT, 64'hFFFF);
    p = flat_pixel(16'h3F00, 16'h7000); send_pixel(p);
    p = flat_pixel(16'h0000, 16'h7000); send_pixel(p);
    p = flat_pixel(16'h2000, 16'h7000); send_pixel(p);
    drain();
  endtask

  // random pixels across several register settings
  task automatic test_random(int phases, int per_phase, bit gaps);
    in_gaps = gaps;
    out_gaps = gaps;
    for (int ph = 0; ph < phases; ph++) begin
      drain();
      randomize_regs(ph == 1);
      for (int i = 0; i < per_phase; i++) send_pixel(rand_pixel());
    end
  endtask

  // result check against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (shaded_q.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, m_axis_tdata);
        errors++;
      end else begin
        logic [47:0] want;
        want = shaded_q.pop_front();
        for (int c = 0; c < 3; c++)
          if (want[16*c +: 16] !== m_axis_tdata[16*c +: 16]) begin
            $display("%0t: channel %0d expected %h actual %h", $time, c,
                     want[16*c +: 16], m_axis_tdata[16*c +: 16]);
            errors++;
          end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (out_gaps && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_valid)
      idle_cycles <= 0;
    else if (shaded_q.size() != 0 || s_axis_tvalid)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    edges_q = '0; levels_q = '0; hue_shift_q = '0; sat_gain_q = 16'd16384;
    spec_thr_q = 16'd16384; spec_gain_q = '0; rim_gain_q = '0; rim_exp_q = 16'd4096;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(6, 180, 1'b1);
    test_random(2, 130, 1'b0);
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
